// ===== rtl/core/tiled_background_scanline_pixel_unit_defines.svh =====
// Assertion macros for the checker file of the background unit.
`ifndef TILED_BACKGROUND_SCANLINE_PIXEL_UNIT_DEFINES_SVH
`define TILED_BACKGROUND_SCANLINE_PIXEL_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TBSPU_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define TBSPU_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== rtl/core/tbspu_pkg.sv =====
`default_nettype none

package tbspu_pkg;

  localparam int VRAM_HALFWORDS  = 32768;
  localparam int VRAM_AW         = $clog2(VRAM_HALFWORDS);
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int LINE_WIDTH      = 240;

  localparam int ADDR_W    = 15;
  localparam int DATA_W    = 16;
  localparam int COORD_W   = 8;
  localparam int SCROLL_W  = 9;
  localparam int CFG_IDX_W = 2;
  localparam int MAP_SUM_W = 16;
  localparam int BYTE_SUM_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_BG_CONTROL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOSAIC_SIZE = 2'd3;

  localparam logic [DATA_W-1:0] COLOR_OPAQUE = 16'h8000;

  typedef enum logic [1:0] {
    ACT_VRAM_WR = 2'd0,
    ACT_PAL_WR  = 2'd1,
    ACT_RENDER  = 2'd2
  } action_t;

  typedef struct packed {
    logic              valid;
    action_t           act;
    logic              live;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } beat_t;

  // Rounded-up 4096 divided by the mosaic block size. An eight-bit coordinate
  // times this value, shifted right by twelve, is the exact block index.
  function automatic logic [12:0] mosaic_recip(input logic [3:0] size_m1);
    logic [12:0] r;
    case (size_m1)
      4'd0:    r = 13'd4096;
      4'd1:    r = 13'd2048;
      4'd2:    r = 13'd1366;
      4'd3:    r = 13'd1024;
      4'd4:    r = 13'd820;
      4'd5:    r = 13'd683;
      4'd6:    r = 13'd586;
      4'd7:    r = 13'd512;
      4'd8:    r = 13'd456;
      4'd9:    r = 13'd410;
      4'd10:   r = 13'd373;
      4'd11:   r = 13'd342;
      4'd12:   r = 13'd316;
      4'd13:   r = 13'd293;
      4'd14:   r = 13'd274;
      default: r = 13'd256;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tiled_background_scanline_pixel_unit.sv =====
// Channel  Handshake             Payload
// input    in_valid, in_stall    in_action, in_mem_addr, in_mem_data, in_column, in_line_number
// result   out_valid, out_stall  out_hit, out_color
// config   cfg_we                cfg_index, cfg_data
//
// Every beat gives one result through stages s1 to s7 and the output register; one
// beat is taken per cycle while in_stall is low. The map is read two stages before
// the video memory write port, and a render beat waits at the input while a video memory write is in s1 to s3.
// Reset is synchronous and clears the valid bits and the configuration registers; the memories
// hold whatever was written. A stalled result freezes all stages at once.
`default_nettype none

module tiled_background_scanline_pixel_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [tbspu_pkg::ADDR_W-1:0]     in_mem_addr,
  input  logic [tbspu_pkg::DATA_W-1:0]     in_mem_data,
  input  logic [tbspu_pkg::COORD_W-1:0]    in_column,
  input  logic [tbspu_pkg::COORD_W-1:0]    in_line_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [tbspu_pkg::DATA_W-1:0]     out_color,
  input  logic                             cfg_we,
  input  logic [tbspu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbspu_pkg::DATA_W-1:0]     cfg_data
);
  import tbspu_pkg::*;

  logic [DATA_W-1:0]   bg_control_r;
  logic [SCROLL_W-1:0] scroll_x_r;
  logic [SCROLL_W-1:0] scroll_y_r;
  logic [7:0]          mosaic_size_r;

  logic [DATA_W-1:0] vram_mem [VRAM_HALFWORDS];
  logic [DATA_W-1:0] pal_mem  [PALETTE_ENTRIES];

  logic en;
  logic hazard;

  beat_t s1_nxt;
  beat_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r;

  logic [19:0]        s1_qx_prod, s1_qy_prod;
  logic [COORD_W-1:0] s1_col_r, s1_lin_r, s1_qx_r, s1_qy_r;
  logic [4:0]         s2_mx, s2_my;
  logic [COORD_W-1:0] s2_x_nxt, s2_y_nxt, s2_x_r, s2_y_r;

  logic [SCROLL_W-1:0]  s3_xs, s3_ys, s3_xx, s3_yy;
  logic [MAP_SUM_W-1:0] s3_map_sum;
  logic [VRAM_AW-1:0]   s3_map_addr_r;
  logic [2:0]           s3_tx_r, s3_ty_r;

  logic [DATA_W-1:0] s4_entry_r;
  logic [2:0]        s4_tx_r, s4_ty_r;
  logic [2:0]        s4_txf, s4_tyf;
  logic [BYTE_SUM_W-1:0] s4_byte_sum;

  logic [VRAM_AW-1:0] s5_tile_addr_r;
  logic               s5_byte_sel_r, s5_nib_sel_r;
  logic [3:0]         s5_bank_r;

  logic [DATA_W-1:0] s6_pair_r;
  logic              s6_byte_sel_r, s6_nib_sel_r;
  logic [3:0]        s6_bank_r;
  logic [7:0]        s6_byte, s6_texel;
  logic [PAL_AW-1:0] s6_pidx;
  logic              s6_opaque_nxt;

  logic [DATA_W-1:0] s7_pal_r;
  logic              s7_opaque_r;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [DATA_W-1:0] out_color_r;

  logic [1:0] cfg_char_base;
  logic [4:0] cfg_screen_base;
  logic       cfg_mosaic_en, cfg_wide, cfg_map_w64, cfg_map_h64;

  assign cfg_char_base   = bg_control_r[3:2];
  assign cfg_mosaic_en   = bg_control_r[6];
  assign cfg_wide        = bg_control_r[7];
  assign cfg_screen_base = bg_control_r[12:8];
  assign cfg_map_w64     = bg_control_r[14];
  assign cfg_map_h64     = bg_control_r[15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_control_r  <= '0;
      scroll_x_r    <= '0;
      scroll_y_r    <= '0;
      mosaic_size_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BG_CONTROL:  bg_control_r  <= cfg_data;
        CFG_SCROLL_X:    scroll_x_r    <= cfg_data[SCROLL_W-1:0];
        CFG_SCROLL_Y:    scroll_y_r    <= cfg_data[SCROLL_W-1:0];
        CFG_MOSAIC_SIZE: mosaic_size_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A render must not read the map before an older video memory write lands.
  assign en = !out_valid_r || !out_stall;
  assign hazard = (in_action == ACT_RENDER) &&
                  ((s1_r.valid && s1_r.act == ACT_VRAM_WR) ||
                   (s2_r.valid && s2_r.act == ACT_VRAM_WR) ||
                   (s3_r.valid && s3_r.act == ACT_VRAM_WR));
  assign in_stall = !en || hazard;

  always_comb begin
    s1_nxt.valid = in_valid && !in_stall;
    s1_nxt.act   = action_t'(in_action);
    s1_nxt.live  = (in_action == ACT_RENDER) && (int'(in_column) < LINE_WIDTH);
    s1_nxt.addr  = in_mem_addr;
    s1_nxt.data  = in_mem_data;
    s1_qx_prod   = {12'b0, in_column} * {7'b0, mosaic_recip(mosaic_size_r[3:0])};
    s1_qy_prod   = {12'b0, in_line_number} * {7'b0, mosaic_recip(mosaic_size_r[7:4])};
  end

  always_comb begin
    s2_mx    = {1'b0, mosaic_size_r[3:0]} + 5'd1;
    s2_my    = {1'b0, mosaic_size_r[7:4]} + 5'd1;
    s2_x_nxt = cfg_mosaic_en ? (s1_qx_r * {3'b0, s2_mx}) : s1_col_r;
    s2_y_nxt = cfg_mosaic_en ? (s1_qy_r * {3'b0, s2_my}) : s1_lin_r;
  end

  always_comb begin
    s3_xs = {1'b0, s2_x_r} + scroll_x_r;
    s3_ys = {1'b0, s2_y_r} + scroll_y_r;
    s3_xx = {s3_xs[8] & cfg_map_w64, s3_xs[7:0]};
    s3_yy = {s3_ys[8] & cfg_map_h64, s3_ys[7:0]};
    s3_map_sum = MAP_SUM_W'({cfg_screen_base, 10'b0})
               + (cfg_map_w64 ? MAP_SUM_W'({s3_yy[8:3], 6'b0})
                              : MAP_SUM_W'({s3_yy[8:3], 5'b0}))
               + MAP_SUM_W'(s3_xx[8:3]);
  end

  always_comb begin
    s4_txf = s4_entry_r[10] ? ~s4_tx_r : s4_tx_r;
    s4_tyf = s4_entry_r[11] ? ~s4_ty_r : s4_ty_r;
    if (cfg_wide) begin
      s4_byte_sum = BYTE_SUM_W'({cfg_char_base, 14'b0})
                  + BYTE_SUM_W'({s4_entry_r[9:0], 6'b0})
                  + BYTE_SUM_W'({s4_tyf, s4_txf});
    end else begin
      s4_byte_sum = BYTE_SUM_W'({cfg_char_base, 14'b0})
                  + BYTE_SUM_W'({s4_entry_r[9:0], 5'b0})
                  + BYTE_SUM_W'({s4_tyf, s4_txf[2:1]});
    end
  end

  always_comb begin
    s6_byte  = s6_byte_sel_r ? s6_pair_r[15:8] : s6_pair_r[7:0];
    if (cfg_wide) begin
      s6_texel = s6_byte;
      s6_pidx  = PAL_AW'(s6_byte);
    end else begin
      s6_texel = {4'b0, s6_nib_sel_r ? s6_byte[7:4] : s6_byte[3:0]};
      s6_pidx  = PAL_AW'({s6_bank_r, s6_texel[3:0]});
    end
    s6_opaque_nxt = s6_r.live && (s6_texel != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid  <= 1'b0;
      s2_r.valid  <= 1'b0;
      s3_r.valid  <= 1'b0;
      s4_r.valid  <= 1'b0;
      s5_r.valid  <= 1'b0;
      s6_r.valid  <= 1'b0;
      s7_r.valid  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_r           <= s1_nxt;
      s1_col_r       <= in_column;
      s1_lin_r       <= in_line_number;
      s1_qx_r        <= s1_qx_prod[19:12];
      s1_qy_r        <= s1_qy_prod[19:12];
      s2_r           <= s1_r;
      s2_x_r         <= s2_x_nxt;
      s2_y_r         <= s2_y_nxt;
      s3_r           <= s2_r;
      s3_map_addr_r  <= s3_map_sum[VRAM_AW-1:0];
      s3_tx_r        <= s3_xx[2:0];
      s3_ty_r        <= s3_yy[2:0];
      s4_r           <= s3_r;
      s4_tx_r        <= s3_tx_r;
      s4_ty_r        <= s3_ty_r;
      s5_r           <= s4_r;
      s5_tile_addr_r <= s4_byte_sum[VRAM_AW:1];
      s5_byte_sel_r  <= s4_byte_sum[0];
      s5_nib_sel_r   <= s4_txf[0];
      s5_bank_r      <= s4_entry_r[15:12];
      s6_r           <= s5_r;
      s6_byte_sel_r  <= s5_byte_sel_r;
      s6_nib_sel_r   <= s5_nib_sel_r;
      s6_bank_r      <= s5_bank_r;
      s7_r           <= s6_r;
      s7_opaque_r    <= s6_opaque_nxt;
      out_valid_r    <= s7_r.valid;
      out_hit_r      <= s7_opaque_r;
      out_color_r    <= s7_opaque_r ? (s7_pal_r | COLOR_OPAQUE) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_entry_r <= vram_mem[s3_map_addr_r];
      s6_pair_r  <= vram_mem[s5_tile_addr_r];
      if (s5_r.valid && s5_r.act == ACT_VRAM_WR) begin
        vram_mem[VRAM_AW'(s5_r.addr)] <= s5_r.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_pal_r <= pal_mem[s6_pidx];
      if (s6_r.valid && s6_r.act == ACT_PAL_WR) begin
        pal_mem[PAL_AW'(s6_r.addr[7:0])] <= s6_r.data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_color = out_color_r;

endmodule

`default_nettype wire

// ===== rtl/core/tbspu_checker.sv =====
`default_nettype none

`include "tiled_background_scanline_pixel_unit_defines.svh"

module tbspu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [15:0] out_color
);

  `TBSPU_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_color), "stalled result beat changed")

  `TBSPU_ASSERT(a_hit_marked, clk, rst_n, out_valid && out_hit |-> out_color[15], "opaque pixel without marker bit")

  `TBSPU_ASSERT(a_miss_zero, clk, rst_n, out_valid && !out_hit |-> out_color == 16'h0000, "empty result with nonzero color")

  `TBSPU_ASSERT(a_backpressure, clk, rst_n, out_valid && out_stall |-> in_stall, "input taken while pipeline frozen")

  `TBSPU_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result beat right after reset")

endmodule

bind tiled_background_scanline_pixel_unit tbspu_checker u_tbspu_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbspu_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  act;
    logic [14:0] addr;
    logic [15:0] data;
    logic [7:0]  col;
    logic [7:0]  lin;
  } pix_req_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] color;
  } pix_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [14:0] in_mem_addr = '0;
  logic [15:0] in_mem_data = '0;
  logic [7:0]  in_column = '0;
  logic [7:0]  in_line_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_hit;
  logic [15:0] out_color;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] bg_ctrl_r = '0;
  logic [8:0]  scroll_x_r = '0;
  logic [8:0]  scroll_y_r = '0;
  logic [7:0]  mosaic_r = '0;

  logic [15:0] vram_img [32768];
  logic [15:0] pal_img [256];
  logic [15:0] plan_vram [32768];
  bit          plan_ok [32768];
  logic [15:0] plan_pal [256];
  bit          plan_pal_ok [256];

  pix_req_t queued_reqs [$];
  pix_out_t expected_pix [$];
  int       issued_cnt = 0;
  int       done_cnt = 0;
  int       errors = 0;
  bit       in_took = 1'b0;

  bit gaps_on = 1'b1;
  int stall_pct = 30;
  int burst_left = 0;
  int gap_left = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_run = 0;
  bit stall_on = 1'b0;

  tiled_background_scanline_pixel_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_mem_addr    (in_mem_addr),
    .in_mem_data    (in_mem_data),
    .in_column      (in_column),
    .in_line_number (in_line_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_color      (out_color),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Background coordinates after mosaic, scroll and wrap to the map size.
  function automatic void scr_pos(input logic [7:0] col, input logic [7:0] lin,
                                  output int xx, output int yy);
    int x, y, mw, mh;
    x = col;
    y = lin;
    if (bg_ctrl_r[6]) begin
      x -= x % (int'(mosaic_r[3:0]) + 1);
      y -= y % (int'(mosaic_r[7:4]) + 1);
    end
    mw = bg_ctrl_r[14] ? 64 : 32;
    mh = bg_ctrl_r[15] ? 64 : 32;
    xx = (x + int'(scroll_x_r)) & (mw * 8 - 1);
    yy = (y + int'(scroll_y_r)) & (mh * 8 - 1);
  endfunction

  function automatic logic [14:0] map_slot(input int xx, input int yy);
    int s;
    s = int'(bg_ctrl_r[12:8]) * 1024 + (yy >> 3) * (bg_ctrl_r[14] ? 64 : 32) + (xx >> 3);
    return 15'(s);
  endfunction

  function automatic logic [15:0] texel_byte(input logic [15:0] entry, input int xx,
                                             input int yy, output logic hi);
    int tx, ty, b;
    tx = entry[10] ? 7 - (xx & 7) : (xx & 7);
    ty = entry[11] ? 7 - (yy & 7) : (yy & 7);
    if (bg_ctrl_r[7]) begin
      b = int'(bg_ctrl_r[3:2]) * 16384 + int'(entry[9:0]) * 64 + ty * 8 + tx;
      hi = 1'b0;
    end else begin
      b = int'(bg_ctrl_r[3:2]) * 16384 + int'(entry[9:0]) * 32 + ((ty * 8 + tx) >> 1);
      hi = tx[0];
    end
    return 16'(b);
  endfunction

  // Bit 8 is set for an opaque texel, bits 7..0 give the palette index.
  function automatic logic [8:0] texel_pick(input logic [15:0] entry, input logic [15:0] hw,
                                            input logic odd, input logic hi);
    logic [7:0] byt;
    logic [3:0] nib;
    byt = odd ? hw[15:8] : hw[7:0];
    nib = hi ? byt[7:4] : byt[3:0];
    if (bg_ctrl_r[7]) return {byt != 8'd0, byt};
    return {nib != 4'd0, entry[15:12], nib};
  endfunction

  function automatic pix_out_t predict_pixel(input pix_req_t r);
    pix_out_t o;
    int xx, yy;
    logic [14:0] slot;
    logic [15:0] baddr;
    logic hi;
    logic [8:0] pk;
    o = '0;
    case (r.act)
      ACT_VRAM_WR: vram_img[r.addr] = r.data;
      ACT_PAL_WR:  pal_img[r.addr[7:0]] = r.data;
      ACT_RENDER: begin
        if (r.col < LINE_WIDTH) begin
          scr_pos(r.col, r.lin, xx, yy);
          slot = map_slot(xx, yy);
          baddr = texel_byte(vram_img[slot], xx, yy, hi);
          pk = texel_pick(vram_img[slot], vram_img[baddr[15:1]], baddr[0], hi);
          if (pk[8]) begin
            o.hit = 1'b1;
            o.color = pal_img[pk[7:0]] | COLOR_OPAQUE;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic queue_req(input pix_req_t r);
    queued_reqs.push_back(r);
    issued_cnt++;
  endtask

  task automatic plan_vram_write(input logic [14:0] addr, input logic [15:0] data);
    plan_vram[addr] = data;
    plan_ok[addr] = 1'b1;
    queue_req('{ACT_VRAM_WR, addr, data, 8'($urandom), 8'($urandom)});
  endtask

  task automatic plan_pal_write(input logic [14:0] addr, input logic [15:0] data);
    plan_pal[addr[7:0]] = data;
    plan_pal_ok[addr[7:0]] = 1'b1;
    queue_req('{ACT_PAL_WR, addr, data, 8'($urandom), 8'($urandom)});
  endtask

  // Every store entry that the pixel will read is written first, with random content.
  task automatic plan_render(input logic [7:0] col, input logic [7:0] lin);
    int xx, yy;
    logic [14:0] slot;
    logic [15:0] baddr;
    logic hi;
    logic [8:0] pk;
    logic [9:0] tile;
    if (col < LINE_WIDTH) begin
      scr_pos(col, lin, xx, yy);
      slot = map_slot(xx, yy);
      if (!plan_ok[slot]) begin
        tile = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(15));
        plan_vram_write(slot, {4'($urandom), 2'($urandom), tile});
      end
      baddr = texel_byte(plan_vram[slot], xx, yy, hi);
      if (!plan_ok[baddr[15:1]]) plan_vram_write(baddr[15:1], 16'($urandom));
      pk = texel_pick(plan_vram[slot], plan_vram[baddr[15:1]], baddr[0], hi);
      if (pk[8] && !plan_pal_ok[pk[7:0]]) plan_pal_write({7'($urandom), pk[7:0]}, 16'($urandom));
    end
    queue_req('{ACT_RENDER, 15'($urandom), 16'($urandom), col, lin});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_BG_CONTROL:  bg_ctrl_r = val;
      CFG_SCROLL_X:    scroll_x_r = val[8:0];
      CFG_SCROLL_Y:    scroll_y_r = val[8:0];
      CFG_MOSAIC_SIZE: mosaic_r = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (done_cnt != issued_cnt) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic tally_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic plan_random_beats(input int count, input int band);
    int goal, k;
    logic [7:0] lin;
    goal = issued_cnt + count;
    while (issued_cnt < goal) begin
      k = $urandom_range(99);
      lin = ($urandom_range(9) < 7) ? 8'(band + $urandom_range(15)) : 8'($urandom);
      if (k < 8) plan_vram_write(15'($urandom), 16'($urandom));
      else if (k < 12) plan_pal_write(15'($urandom), 16'($urandom));
      else if (k < 15) queue_req('{ACT_SPARE, 15'($urandom), 16'($urandom), 8'($urandom),
                                   8'($urandom)});
      else if (k < 20) plan_render(8'($urandom_range(255, 240)), lin);
      else plan_render(8'($urandom_range(239)), lin);
    end
  endtask

  always @(negedge clk) begin : drive_beats
    pix_req_t cur;
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_reqs.size() > 0) begin
        cur = queued_reqs.pop_front();
        in_action <= cur.act;
        in_mem_addr <= cur.addr;
        in_mem_data <= cur.data;
        in_column <= cur.col;
        in_line_number <= cur.lin;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(24);
          gap_left = gaps_on ? $urandom_range(6, 1) : 0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        hold_left = 150;
        out_stall <= 1'b1;
      end else begin
        if (stall_run == 0) begin
          stall_on = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
          stall_run = $urandom_range(8, 1);
        end
        stall_run--;
        out_stall <= stall_on;
      end
    end
  end

  always @(posedge clk) begin : watch_beats
    pix_out_t want;
    if (rst_n) begin
      in_took = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_pix.size() == 0) begin
          tally_mismatch($sformatf("result beat hit=%0d color=%h with nothing pending",
                                   out_hit, out_color));
        end else begin
          want = expected_pix.pop_front();
          done_cnt++;
          if (out_hit !== want.hit)
            tally_mismatch($sformatf("hit %b, want %b", out_hit, want.hit));
          if (out_color !== want.color)
            tally_mismatch($sformatf("color %h, want %h", out_color, want.color));
        end
      end
      if (in_took) begin
        expected_pix.push_back(predict_pixel('{in_action, in_mem_addr, in_mem_data,
                                               in_column, in_line_number}));
      end
    end else begin
      in_took = 1'b0;
    end
  end

  initial begin : stimulus
    logic [15:0] ctl;
    logic [8:0]  sx, sy;
    logic [7:0]  mos;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: store extremes, the spare action, edge pixels and renders right behind video memory writes.
    plan_vram_write(15'h7FFF, 16'hFFFF);
    plan_vram_write(15'h0000, 16'h0000);
    plan_pal_write(15'h7FFF, 16'h7FFF);
    plan_pal_write(15'h0000, 16'h0000);
    queue_req('{ACT_SPARE, 15'h7FFF, 16'hFFFF, 8'hFF, 8'hFF});
    plan_render(8'd0, 8'd0);
    plan_render(8'd239, 8'd255);
    plan_render(8'd240, 8'd0);
    plan_render(8'd255, 8'd255);
    plan_vram_write(15'd1, 16'hFC01);
    plan_render(8'd8, 8'd0);
    plan_render(8'd15, 8'd7);
    plan_vram_write(15'd1, 16'h3002);
    plan_render(8'd9, 8'd1);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin
          ctl = 16'hFFFF; sx = 9'h1FF; sy = 9'h1FF; mos = 8'hFF;
        end
        1: begin
          ctl = 16'($urandom) | 16'h0040; sx = 9'($urandom); sy = 9'($urandom); mos = 8'h00;
        end
        8: begin
          ctl = 16'h0000; sx = 9'h000; sy = 9'h000; mos = 8'h00;
        end
        default: begin
          ctl = 16'($urandom); sx = 9'($urandom); sy = 9'($urandom); mos = 8'($urandom);
        end
      endcase
      write_reg(CFG_BG_CONTROL, ctl);
      write_reg(CFG_SCROLL_X, {7'd0, sx});
      write_reg(CFG_SCROLL_Y, {7'd0, sy});
      write_reg(CFG_MOSAIC_SIZE, {8'd0, mos});
      gaps_on = (p % 3 != 2);
      stall_pct = (p % 4 == 1) ? 0 : $urandom_range(70, 15);
      if (p == 3) begin
        plan_random_beats(60, $urandom_range(240));
        hold_req++;
        wait_drained();
        plan_random_beats(60, $urandom_range(240));
      end else begin
        plan_random_beats(120, $urandom_range(240));
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_pix.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ===== tiled_background_scanline_pixel_unit.f =====
+incdir+rtl/core
rtl/core/tbspu_pkg.sv
rtl/core/tiled_background_scanline_pixel_unit.sv
rtl/core/tbspu_checker.sv
tb/tb.sv
